@@ rtl/core/pfla_pkg.sv @@
// Shared types and constants for the page free-list allocator.
package pfla_pkg;

   localparam int unsigned PAGE_ID_W    = 12;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned COUNT_W      = 13;
   localparam int unsigned REQ_DATA_W   = 16;
   localparam int unsigned RSP_DATA_W   = 40;

   localparam logic [COUNT_W-1:0] LIVE_MAX = 13'd8191;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_FREE = 2'd1,
      STATUS_NO_SPACE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      IDLE,
      EXEC,
      EXPAND,
      POP,
      RESP
   } fsm_state_type;

   // Sequencer to walk unit.
   typedef struct packed {
      logic start;
   } walk_ctrl_type;

   // Walk unit back to sequencer.
   typedef struct packed {
      logic active;
      logic last;
   } walk_sts_type;

endpackage

@@ rtl/core/page_free_list_allocator_unit.sv @@
// Top level of the page free-list allocator: sequencer, list state and result register.
//
//  channel | dir | handshake             | contents
//  req     | in  | req_tvalid/req_tready | tuser: req_type; tdata: page_id
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: granted_page, status, live_pages, page_limit
//
// rsp_tvalid rises when a free or failed allocate has passed EXEC and RESP, or an allocate
// from a non-empty list has passed EXEC, POP (the registered link memory read) and RESP;
// RESP holds while an older result is untaken. The state is back in idle as rsp_tvalid
// rises, and the next item is taken there. On an empty list the walker first links up to
// BATCH fresh pages in EXPAND, one link memory entry per cycle, then EXEC and POP follow.
// Synchronous reset leaves the list empty, the limit at 1 and the count at 0;
// the link memory is not cleared. A new item is taken only in the idle state,
// and a result waits in its register until rsp_tready takes it.
module page_free_list_allocator_unit
   import pfla_pkg::*;
#(
   parameter int unsigned MAX_PAGES = 4096,
   parameter int unsigned BATCH     = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [11:0] page_id, [15:12] zero
   input  logic                  req_tuser,  // [0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [11:0] granted_page, [13:12] status, [26:14] live_pages, [39:27] page_limit
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned PW = $clog2(MAX_PAGES);
   localparam int unsigned LW = $clog2(MAX_PAGES + 1);
   localparam int unsigned CW = (LW > PAGE_ID_W) ? LW : PAGE_ID_W;

   fsm_state_type state_ff, state_in;
   req_kind_type  kind_ff, kind_in;
   logic [PAGE_ID_W-1:0] pid_ff, pid_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [LW-1:0]        limit_ff, limit_in;
   logic [COUNT_W-1:0]   live_ff, live_in;
   logic [PAGE_ID_W-1:0] granted_ff, granted_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   walk_ctrl_type walk_ctrl;
   walk_sts_type  walk_sts;
   logic [PW-1:0] walk_addr, walk_data;
   logic [LW-1:0] walk_end;

   logic          mem_we, mem_re;
   logic [PW-1:0] mem_waddr, mem_wdata, mem_rdata;
   logic          free_bad;

   assign free_bad = (pid_ff == '0) || (CW'(pid_ff) >= CW'(limit_ff));

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      pid_in       = pid_ff;
      head_in      = head_ff;
      limit_in     = limit_ff;
      live_in      = live_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      walk_ctrl    = '0;
      mem_we       = 1'b0;
      mem_waddr    = walk_addr;
      mem_wdata    = walk_data;
      mem_re       = 1'b0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = req_kind_type'(req_tuser);
               pid_in   = req_tdata[PAGE_ID_W-1:0];
               state_in = EXEC;
            end
         end
         EXEC: begin
            granted_in = '0;
            status_in  = STATUS_OK;
            if (kind_ff == REQ_FREE) begin
               if (free_bad) begin
                  status_in = STATUS_BAD_FREE;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = PW'(pid_ff);
                  mem_wdata = head_ff;
                  head_in   = PW'(pid_ff);
                  if (live_ff != '0) begin
                     live_in = live_ff - COUNT_W'(1);
                  end
               end
               state_in = RESP;
            end else if (head_ff != '0) begin
               mem_re   = 1'b1;
               state_in = POP;
            end else if (limit_ff >= LW'(MAX_PAGES)) begin
               status_in = STATUS_NO_SPACE;
               state_in  = RESP;
            end else begin
               walk_ctrl.start = 1'b1;
               state_in        = EXPAND;
            end
         end
         EXPAND: begin
            mem_we = walk_sts.active;
            if (walk_sts.last) begin
               head_in  = limit_ff[PW-1:0];
               limit_in = walk_end;
               state_in = EXEC;
            end
         end
         POP: begin
            granted_in = PAGE_ID_W'(head_ff);
            head_in    = mem_rdata;
            if (live_ff < LIVE_MAX) begin
               live_in = live_ff + COUNT_W'(1);
            end
            state_in = RESP;
         end
         RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {COUNT_W'(limit_ff), live_ff, status_ff, granted_ff};
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         limit_ff     <= LW'(1);
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         limit_ff     <= limit_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pid_ff      <= pid_in;
      granted_ff  <= granted_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   pfla_walk_unit #(
      .MAX_PAGES (MAX_PAGES),
      .BATCH     (BATCH),
      .PW        (PW),
      .LW        (LW)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (walk_ctrl),
      .first_page (limit_ff),
      .head_page  (head_ff),
      .sts        (walk_sts),
      .wr_addr    (walk_addr),
      .wr_data    (walk_data),
      .end_page   (walk_end)
   );

   pfla_link_mem #(
      .DEPTH (MAX_PAGES),
      .AW    (PW)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (head_ff),
      .rd_data (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/core/pfla_link_mem.sv @@
// Link memory: one write port and one registered read port.
module pfla_link_mem
   import pfla_pkg::*;
#(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [AW-1:0] rd_data
);

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pfla_walk_unit.sv @@
// Expansion walker: links a run of fresh pages, one link write per cycle.
module pfla_walk_unit
   import pfla_pkg::*;
#(
   parameter int unsigned MAX_PAGES = 4096,
   parameter int unsigned BATCH     = 1024,
   parameter int unsigned PW        = 12,
   parameter int unsigned LW        = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  walk_ctrl_type ctrl,
   input  logic [LW-1:0] first_page,
   input  logic [PW-1:0] head_page,
   output walk_sts_type  sts,
   output logic [PW-1:0] wr_addr,
   output logic [PW-1:0] wr_data,
   output logic [LW-1:0] end_page
);

   localparam int unsigned SW = $clog2(MAX_PAGES + BATCH + 1);
   localparam logic [SW-1:0] BATCH_S = SW'(BATCH);
   localparam logic [SW-1:0] MAX_S   = SW'(MAX_PAGES);

   logic          active_ff, active_in;
   logic [LW-1:0] page_ff, page_in;
   logic [LW-1:0] end_ff, end_in;
   logic [SW-1:0] sum;
   logic [LW-1:0] page_next;
   logic          last;

   // The single incrementer and end compare serve every step of the walk.
   assign page_next = page_ff + LW'(1);
   assign last      = (page_next == end_ff);
   assign sum       = SW'(first_page) + BATCH_S;

   always_comb begin
      active_in = active_ff;
      page_in   = page_ff;
      end_in    = end_ff;
      if (ctrl.start) begin
         active_in = 1'b1;
         page_in   = first_page;
         end_in    = (sum > MAX_S) ? LW'(MAX_PAGES) : LW'(sum);
      end else if (active_ff) begin
         page_in   = page_next;
         active_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      end_ff  <= end_in;
   end

   assign sts.active = active_ff;
   assign sts.last   = active_ff && last;
   assign wr_addr    = page_ff[PW-1:0];
   // The final fresh page links to the old head of the list.
   assign wr_data    = last ? head_page : page_next[PW-1:0];
   assign end_page   = end_ff;

endmodule
